// ===== rtl/pprt_pkg.sv =====
// Shared types and constants for the progress percentile rank table.
// No dependencies; used by pprt_div and the top level.
package pprt_pkg;

   // Fixed field widths of the request and response items
   localparam int MODE_W     = 1;
   localparam int ID_IN_W    = 17;
   localparam int LEVEL_IN_W = 10;
   localparam int RANK_W     = 17;

   // Fraction bits of the Q1.16 rank
   localparam int FRAC_W = 16;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_RECORD = 1'b0;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 1'b1;

   // Rank of exactly one
   localparam logic [RANK_W-1:0] RANK_ONE  = 17'h10000;
   localparam logic [RANK_W-1:0] RANK_ZERO = 17'h00000;

endpackage

// ===== rtl/progress_percentile_rank_table_top.sv =====
// Progress percentile rank table: per-identifier progress memory, level
// histogram memory, known count, and a sequencer. Depends on pprt_pkg, pprt_div.
//
// Usage:
//   Request channel (req_*): mode 0 records req_level as the identifier's
//   progress and gives no response; mode 1 queries and gives one response.
//   Response channel (rsp_*): rank_fraction, the share of the other known
//   identifiers strictly behind, unsigned Q1.16 rounded down (65536 = one).
//   One item is worked on at a time; req_ready is high only while idle.
//   A record reads the identifier's entry, then for a known one decrements
//   its old bin; it then increments the new bin. A record whose id or level is
//   out of range is dropped. A query that divides first sums the bins below
//   the queried level, the histogram port reading one bin per cycle, then
//   runs the serial divider.
//   After reset a clearing pass writes both memories, one entry per cycle,
//   until every entry is cleared; req_ready stays low during it.
//   The response sits in an output register; a new item is accepted while it
//   waits. If the receiver stalls, a finished query holds in its last state
//   until the register frees.
module progress_percentile_rank_table_top #(
   parameter int ID_COUNT    = 131072,
   parameter int LEVEL_COUNT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pprt_pkg::MODE_W-1:0]     req_mode,
   input  logic [pprt_pkg::ID_IN_W-1:0]    req_user_id,
   input  logic [pprt_pkg::LEVEL_IN_W-1:0] req_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pprt_pkg::RANK_W-1:0]     rsp_rank_fraction
);
   import pprt_pkg::*;

   localparam int ID_W      = $clog2(ID_COUNT);
   localparam int LEVEL_W   = $clog2(LEVEL_COUNT);
   localparam int CNT_W     = $clog2(ID_COUNT + 1);
   localparam int ENTRY_W   = LEVEL_W + 1;
   localparam int CLR_COUNT = (ID_COUNT > LEVEL_COUNT) ? ID_COUNT : LEVEL_COUNT;
   localparam int CLR_W     = $clog2(CLR_COUNT);

   // Sequencer states
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_CLEAR  = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
   localparam logic [ST_W-1:0] ST_ENTRY  = 4'd2;
   localparam logic [ST_W-1:0] ST_OLD    = 4'd3;
   localparam logic [ST_W-1:0] ST_ISSUE  = 4'd4;
   localparam logic [ST_W-1:0] ST_NEW    = 4'd5;
   localparam logic [ST_W-1:0] ST_SCAN   = 4'd6;
   localparam logic [ST_W-1:0] ST_DIVGO  = 4'd7;
   localparam logic [ST_W-1:0] ST_DIVRUN = 4'd8;
   localparam logic [ST_W-1:0] ST_RESULT = 4'd9;

   // Control registers
   logic [ST_W-1:0]    state_ff, state_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0]   known_ff, known_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Item registers
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [ID_W-1:0]    idx_ff, idx_in;
   logic [LEVEL_W-1:0] new_lvl_ff, new_lvl_in;
   logic [LEVEL_W-1:0] old_lvl_ff, old_lvl_in;
   logic [LEVEL_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0]   sum_ff, sum_in;
   logic [RANK_W-1:0]  res_ff, res_in;
   logic [RANK_W-1:0]  rsp_data_ff, rsp_data_in;

   // Memories and their ports
   logic [ENTRY_W-1:0] prog_mem [ID_COUNT];
   logic [CNT_W-1:0]   hist_mem [LEVEL_COUNT];
   logic [ENTRY_W-1:0] prog_q_ff;
   logic [CNT_W-1:0]   hist_q_ff;
   logic [ID_W-1:0]    prog_raddr, prog_waddr;
   logic [ENTRY_W-1:0] prog_wdata;
   logic               prog_we;
   logic [LEVEL_W-1:0] hist_raddr, hist_waddr;
   logic [CNT_W-1:0]   hist_wdata;
   logic               hist_we;

   // Divider hookup
   logic               div_start;
   logic               div_done;
   logic [FRAC_W-1:0]  div_quo;
   logic [CNT_W-1:0]   others;

   // Request decode
   logic               req_fire;
   logic [31:0]        id_wide;
   logic [31:0]        lvl_wide;
   logic               id_ok;
   logic               lvl_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign id_wide   = 32'(req_user_id);
   assign lvl_wide  = 32'(req_level);
   assign id_ok     = (id_wide < 32'(ID_COUNT));
   assign lvl_ok    = (lvl_wide < 32'(LEVEL_COUNT));
   assign others    = known_ff - 1'b1;

   // Sequencer and memory port control
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      known_in     = known_ff;
      pend_in      = pend_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      new_lvl_in   = new_lvl_ff;
      old_lvl_in   = old_lvl_ff;
      scan_in      = scan_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      prog_raddr   = id_wide[ID_W-1:0];
      prog_we      = 1'b0;
      prog_waddr   = idx_ff;
      prog_wdata   = {1'b1, new_lvl_ff};
      hist_raddr   = new_lvl_ff;
      hist_we      = 1'b0;
      hist_waddr   = new_lvl_ff;
      hist_wdata   = hist_q_ff + 1'b1;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            prog_we    = (32'(clr_ff) < 32'(ID_COUNT));
            prog_waddr = clr_ff[ID_W-1:0];
            prog_wdata = '0;
            hist_we    = (32'(clr_ff) < 32'(LEVEL_COUNT));
            hist_waddr = clr_ff[LEVEL_W-1:0];
            hist_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               mode_in    = req_mode;
               idx_in     = id_wide[ID_W-1:0];
               new_lvl_in = lvl_wide[LEVEL_W-1:0];
               if (req_mode == MODE_QUERY) begin
                  if (id_ok) begin
                     state_in = ST_ENTRY;
                  end else begin
                     res_in   = RANK_ZERO;
                     state_in = ST_RESULT;
                  end
               end else if (id_ok && lvl_ok) begin
                  state_in = ST_ENTRY;
               end
            end
         end
         // Progress entry is now out of the memory
         ST_ENTRY: begin
            if (mode_ff == MODE_RECORD) begin
               prog_we = 1'b1;
               if (prog_q_ff[LEVEL_W]) begin
                  hist_raddr = prog_q_ff[LEVEL_W-1:0];
                  old_lvl_in = prog_q_ff[LEVEL_W-1:0];
                  state_in   = ST_OLD;
               end else begin
                  known_in = known_ff + 1'b1;
                  state_in = ST_NEW;
               end
            end else if (prog_q_ff[LEVEL_W]) begin
               old_lvl_in = prog_q_ff[LEVEL_W-1:0];
               scan_in    = '0;
               sum_in     = '0;
               pend_in    = 1'b0;
               state_in   = ST_SCAN;
            end else begin
               res_in   = RANK_ZERO;
               state_in = ST_RESULT;
            end
         end
         // Take the item out of its old bin
         ST_OLD: begin
            hist_we    = 1'b1;
            hist_waddr = old_lvl_ff;
            hist_wdata = hist_q_ff - 1'b1;
            state_in   = ST_ISSUE;
         end
         // Read the new bin after the old one is written back
         ST_ISSUE: begin
            state_in = ST_NEW;
         end
         ST_NEW: begin
            hist_we  = 1'b1;
            state_in = ST_IDLE;
         end
         // Sum bins below the queried level, one read per cycle
         ST_SCAN: begin
            hist_raddr = scan_ff;
            if (pend_ff) begin
               sum_in = sum_ff + hist_q_ff;
            end
            if (scan_ff != old_lvl_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DIVGO;
            end
         end
         // Alone or ahead of everyone gives one, else divide
         ST_DIVGO: begin
            if (sum_ff == others) begin
               res_in   = RANK_ONE;
               state_in = ST_RESULT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVRUN;
            end
         end
         ST_DIVRUN: begin
            if (div_done) begin
               res_in   = {1'b0, div_quo};
               state_in = ST_RESULT;
            end
         end
         // Hand over once the output register is free
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         known_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         known_ff     <= known_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      new_lvl_ff  <= new_lvl_in;
      old_lvl_ff  <= old_lvl_in;
      scan_ff     <= scan_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Progress table: valid bit over level
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_waddr] <= prog_wdata;
      end
      prog_q_ff <= prog_mem[prog_raddr];
   end

   // Level histogram
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_q_ff <= hist_mem[hist_raddr];
   end

   pprt_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_ff),
      .den   (others),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rank_fraction = rsp_data_ff;

endmodule

// ===== rtl/pprt_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den).
// Expects num < den. Depends on pprt_pkg.
module pprt_div #(
   parameter int CNT_W = 18
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [CNT_W-1:0]           num,
   input  logic [CNT_W-1:0]           den,
   output logic                       done,
   output logic [pprt_pkg::FRAC_W-1:0] quo
);
   import pprt_pkg::*;

   localparam int STEP_W = $clog2(FRAC_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  den_ff;
   logic [FRAC_W-1:0] quo_ff;

   logic [CNT_W:0]    rem2;
   logic [CNT_W:0]    diff;
   logic              fits;

   // Shift remainder up and try to take the divisor off
   always_comb begin
      rem2 = {rem_ff, 1'b0};
      diff = rem2 - {1'b0, den_ff};
      fits = (rem2 >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(FRAC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: no reset needed
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         den_ff <= den;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[CNT_W-1:0] : rem2[CNT_W-1:0];
         quo_ff <= {quo_ff[FRAC_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== bench/pprt_rank_checker.sv =====
`timescale 1ns / 100ps
// Checker for the progress percentile rank table: watches both channels, keeps its
// own progress table and level histogram, and compares every rank result. Uses pprt_pkg.
module pprt_rank_checker #(
   parameter int ID_COUNT    = 131072,
   parameter int LEVEL_COUNT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [pprt_pkg::MODE_W-1:0]     req_mode,
   input  logic [pprt_pkg::ID_IN_W-1:0]    req_user_id,
   input  logic [pprt_pkg::LEVEL_IN_W-1:0] req_level,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [pprt_pkg::RANK_W-1:0]     rsp_rank_fraction,
   output int unsigned                     mismatches,
   output int unsigned                     outstanding,
   output int unsigned                     ranks_checked
);
   import pprt_pkg::*;

   typedef struct packed {
      logic [ID_IN_W-1:0] user_id;
      logic [RANK_W-1:0]  rank;
   } rank_expect_type;

   // Shadow state of the block
   bit                    id_known [ID_COUNT];
   bit [LEVEL_IN_W-1:0]   id_level [ID_COUNT];
   int unsigned           level_bins [LEVEL_COUNT];
   int unsigned           known_ids;

   rank_expect_type       pending_ranks [$];
   rank_expect_type       oldest;

   task automatic report_mismatch(input string what);
      $display("[%0t] rank check: %s", $realtime, what);
      mismatches++;
   endtask

   // Record item: move the identifier between bins, or add it if new
   function automatic void apply_progress(input logic [ID_IN_W-1:0] id,
                                          input logic [LEVEL_IN_W-1:0] lvl);
      if (id >= ID_COUNT || lvl >= LEVEL_COUNT)
         return;
      if (id_known[id])
         level_bins[id_level[id]]--;
      else
         known_ids++;
      id_known[id] = 1'b1;
      id_level[id] = lvl;
      level_bins[lvl]++;
   endfunction

   // Query item: share of the other known identifiers strictly behind, Q1.16
   function automatic logic [RANK_W-1:0] predict_rank(input logic [ID_IN_W-1:0] id);
      longint unsigned behind;
      longint unsigned others;
      longint unsigned quotient;
      int unsigned     lvl;
      behind = 0;
      if (id >= ID_COUNT || !id_known[id])
         return RANK_ZERO;
      lvl = 32'(id_level[id]);
      if (lvl >= LEVEL_COUNT || known_ids == 0)
         return RANK_ZERO;
      for (int i = 0; i < lvl; i++)
         behind += 64'(level_bins[i]);
      others = 64'(known_ids - 1);
      // ahead of everyone else, or alone
      if (behind == others)
         return RANK_ONE;
      // everyone on one level
      if (known_ids == level_bins[lvl] || others == 0)
         return RANK_ZERO;
      quotient = (behind << FRAC_W) / others;
      return quotient[RANK_W-1:0];
   endfunction

   // Results are retired before the item of the same edge is taken in
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_ranks.size() == 0) begin
               report_mismatch($sformatf("rank %0d with no query waiting", rsp_rank_fraction));
            end else begin
               oldest = pending_ranks.pop_front();
               ranks_checked++;
               if (rsp_rank_fraction !== oldest.rank)
                  report_mismatch($sformatf("id %0d rank_fraction %0d, expected %0d",
                                            oldest.user_id, rsp_rank_fraction, oldest.rank));
            end
         end
         if (req_valid && req_ready) begin
            if (req_mode == MODE_QUERY)
               pending_ranks.push_back('{user_id: req_user_id,
                                         rank: predict_rank(req_user_id)});
            else
               apply_progress(req_user_id, req_level);
         end
      end
      outstanding = pending_ranks.size();
   end

endmodule

// ===== bench/progress_percentile_rank_table_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the progress percentile rank table: clock, reset, request and
// response drivers, and the verdict. Depends on pprt_pkg, the block and pprt_rank_checker.
module progress_percentile_rank_table_top_tb;
   import pprt_pkg::*;

   localparam int ID_COUNT          = 131072;
   localparam int LEVEL_COUNT       = 1024;
   localparam logic [ID_IN_W-1:0] ID_MAX = ID_IN_W'(ID_COUNT - 1);
   localparam int RANDOM_ITEMS      = 518;
   localparam int PRESSURE_AT       = 100;
   localparam int LONG_HOLD_CYCLES  = 400;
   localparam int DRAIN_LIMIT       = 20000;
   localparam int SETTLE_CYCLES     = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode = MODE_RECORD;
   logic [ID_IN_W-1:0]    req_user_id = '0;
   logic [LEVEL_IN_W-1:0] req_level = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RANK_W-1:0]     rsp_rank_fraction;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned ranks_checked;
   int unsigned record_items;
   int unsigned query_items;
   int unsigned burst_left;
   bit          hold_req = 1'b0;

   always #10 clock = ~clock;

   progress_percentile_rank_table_top #(
      .ID_COUNT    (ID_COUNT),
      .LEVEL_COUNT (LEVEL_COUNT)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_user_id       (req_user_id),
      .req_level         (req_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rank_fraction (rsp_rank_fraction)
   );

   pprt_rank_checker #(
      .ID_COUNT    (ID_COUNT),
      .LEVEL_COUNT (LEVEL_COUNT)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_user_id       (req_user_id),
      .req_level         (req_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rank_fraction (rsp_rank_fraction),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .ranks_checked     (ranks_checked)
   );

   // Idle length: mostly short, now and then long
   function automatic int unsigned idle_length();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // Offer one item, hold it until taken, then maybe idle
   task automatic push_request(input logic [MODE_W-1:0]     mode,
                               input logic [ID_IN_W-1:0]    id,
                               input logic [LEVEL_IN_W-1:0] pages);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_user_id <= id;
      req_level   <= pages;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (mode == MODE_QUERY)
         query_items++;
      else
         record_items++;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 2) == 0) begin
         gap = 0;
      end else begin
         gap = idle_length();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: random ready runs and stalls, plus one long hold-off
   initial begin : rsp_side
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (idle_length()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Overall time limit
   initial begin : run_limit
      #100_000_000;
      $display("FAILURE");
      $finish;
   end

   // Stimulus and verdict
   initial begin : req_side
      int unsigned          pick;
      int unsigned          drain_cycles;
      logic [MODE_W-1:0]    mode;
      logic [ID_IN_W-1:0]   id;
      logic [LEVEL_IN_W-1:0] pages;
      burst_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, lone id, top level, ties, same-level rewrite, one level
      push_request(MODE_QUERY,  0,      0);
      push_request(MODE_QUERY,  ID_MAX, 0);
      push_request(MODE_RECORD, 5,      10);
      push_request(MODE_QUERY,  5,      0);
      push_request(MODE_RECORD, ID_MAX, 1023);
      push_request(MODE_QUERY,  ID_MAX, 1023);
      push_request(MODE_QUERY,  5,      0);
      push_request(MODE_RECORD, 7,      10);
      push_request(MODE_QUERY,  5,      0);
      push_request(MODE_RECORD, 0,      0);
      push_request(MODE_QUERY,  5,      1023);
      push_request(MODE_RECORD, 5,      10);
      push_request(MODE_QUERY,  5,      0);
      push_request(MODE_RECORD, 5,      500);
      push_request(MODE_QUERY,  5,      0);
      push_request(MODE_QUERY,  100,    0);
      push_request(MODE_RECORD, 0,      500);
      push_request(MODE_RECORD, 7,      500);
      push_request(MODE_RECORD, ID_MAX, 500);
      push_request(MODE_QUERY,  7,      0);
      push_request(MODE_RECORD, ID_MAX, 0);
      push_request(MODE_QUERY,  5,      0);
      push_request(MODE_QUERY,  ID_MAX, 0);

      // Random: a busy pool of ids at low and high ends, strays that are mostly unknown
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PRESSURE_AT) begin
            hold_req   <= 1'b1;
            burst_left = 30;
         end else if (burst_left == 0 && $urandom_range(0, 59) == 0) begin
            burst_left = 12;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60)
            id = ID_IN_W'($urandom_range(0, 39));
         else if (pick < 75)
            id = ID_IN_W'($urandom_range(ID_MAX - 39, ID_MAX));
         else
            id = ID_IN_W'($urandom);
         // low levels keep most queries short
         pick = $urandom_range(0, 99);
         if (pick < 80)
            pages = LEVEL_IN_W'($urandom_range(0, 63));
         else if (pick < 92)
            pages = LEVEL_IN_W'($urandom_range(64, 959));
         else
            pages = LEVEL_IN_W'($urandom_range(960, LEVEL_COUNT - 1));
         mode = ($urandom_range(0, 99) < 45) ? MODE_RECORD : MODE_QUERY;
         push_request(mode, id, pages);
      end
      req_valid <= 1'b0;

      // Drain, then let a trailing record finish
      drain_cycles = 0;
      while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d record and %0d query items, %0d rank results compared.",
               record_items, query_items, ranks_checked);
      $display("Included a %0d-cycle receiver hold-off with the sender offering back to back.",
               LONG_HOLD_CYCLES);
      if (outstanding != 0)
         $display("%0d expected rank results never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
